@@ rtl/csv_pkg.sv @@
// Package for the callsign/SSID validator: phase type, character classes,
// grammar limits and ASCII codes. No dependencies.
package csv_pkg;

  typedef enum logic [1:0] {
    PH_BASE,
    PH_SEC,
    PH_SSID
  } phase_e;

  typedef struct packed {
    logic       is_digit;
    logic       is_alnum;
    logic       is_slash;
    logic       is_dash;
    logic [3:0] digit;
  } char_class_t;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  localparam logic [4:0] TOTAL_MIN = 5'd3;
  localparam logic [4:0] TOTAL_MAX = 5'd15;
  localparam logic [4:0] TOTAL_SAT = 5'd31;
  localparam logic [3:0] BASE_MIN  = 4'd3;
  localparam logic [3:0] BASE_MAX  = 4'd8;
  localparam logic [3:0] BASE_SAT  = 4'd15;
  localparam logic [2:0] SEC_MIN   = 3'd1;
  localparam logic [2:0] SEC_MAX   = 3'd3;
  localparam logic [2:0] SEC_SAT   = 3'd7;
  localparam logic [4:0] SSID_MAX  = 5'd15;
  localparam logic [4:0] SSID_CLAMP = 5'd16;
  localparam logic [1:0] SSID_DIG_SAT = 2'd3;

endpackage

@@ rtl/csv_in_if.sv @@
// Input channel of the callsign validator: one character word per handshake.
// Depends on nothing.
interface csv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       is_last;

  modport source (output valid, output ch, output is_last, input ready);
  modport sink (input valid, input ch, input is_last, output ready);
endinterface

@@ rtl/csv_out_if.sv @@
// Output channel of the callsign validator: one verdict word per callsign.
// Depends on nothing.
interface csv_out_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink (input valid, input valid_res, output ready);
endinterface

@@ rtl/csv_classify.sv @@
// Character classifier: digit, letter, slash and dash decode of one byte.
// Depends on csv_pkg.
module csv_classify
  import csv_pkg::*;
(
  input  logic [7:0]  ch_i,
  output char_class_t cls_o
);

  logic is_digit;
  logic is_upper;
  logic is_lower;

  always_comb begin
    is_digit = (ch_i >= CH_0) && (ch_i <= CH_9);
    is_upper = (ch_i >= CH_UA) && (ch_i <= CH_UZ);
    is_lower = (ch_i >= CH_LA) && (ch_i <= CH_LZ);
    cls_o.is_digit = is_digit;
    cls_o.is_alnum = is_digit || is_upper || is_lower;
    cls_o.is_slash = (ch_i == CH_SLASH);
    cls_o.is_dash  = (ch_i == CH_DASH);
    // Low nibble of an ASCII digit is its value.
    cls_o.digit    = ch_i[3:0];
  end

endmodule

@@ rtl/csv_track.sv @@
// Grammar tracker: phase register, counters and flags, and the verdict
// computed from the state after the current character. Depends on csv_pkg.
module csv_track
  import csv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        last_i,
  input  char_class_t cls_i,
  output logic        verdict_o
);

  phase_e     phase_q, phase_d;
  logic [4:0] total_q, total_d;
  logic [3:0] base_q, base_d;
  logic       dig1_q, dig1_d;
  logic       dig2_q, dig2_d;
  logic [2:0] sec_q, sec_d;
  logic [4:0] ssid_val_q, ssid_val_d;
  logic [1:0] ssid_dig_q, ssid_dig_d;
  logic       failed_q, failed_d;

  logic [7:0] ssid_next;
  logic       sec_ok_cur;
  logic       sec_ok_next;
  logic       base_ok;

  always_comb begin
    phase_d    = phase_q;
    total_d    = (total_q < TOTAL_SAT) ? total_q + 5'd1 : total_q;
    base_d     = base_q;
    dig1_d     = dig1_q;
    dig2_d     = dig2_q;
    sec_d      = sec_q;
    ssid_val_d = ssid_val_q;
    ssid_dig_d = ssid_dig_q;
    failed_d   = failed_q;
    sec_ok_cur = (sec_q >= SEC_MIN) && (sec_q <= SEC_MAX);
    // Times ten as two shifts and an add; the clamped value is at most 16.
    ssid_next  = {ssid_val_q, 3'b000} + {2'b00, ssid_val_q, 1'b0} + {4'b0000, cls_i.digit};

    if (!failed_q) begin
      unique case (phase_q)
        PH_BASE: begin
          if (cls_i.is_alnum) begin
            if (base_q == 4'd1 && cls_i.is_digit) dig1_d = 1'b1;
            if (base_q == 4'd2 && cls_i.is_digit) dig2_d = 1'b1;
            if (base_q < BASE_SAT) base_d = base_q + 4'd1;
          end else if (cls_i.is_slash) begin
            phase_d = PH_SEC;
          end else if (cls_i.is_dash) begin
            phase_d = PH_SSID;
          end else begin
            failed_d = 1'b1;
          end
        end
        PH_SEC: begin
          if (cls_i.is_alnum) begin
            if (sec_q < SEC_SAT) sec_d = sec_q + 3'd1;
          end else if (cls_i.is_dash) begin
            if (!sec_ok_cur) failed_d = 1'b1;
            phase_d = PH_SSID;
          end else begin
            failed_d = 1'b1;
          end
        end
        PH_SSID: begin
          if (cls_i.is_digit) begin
            ssid_val_d = (ssid_next > {3'b000, SSID_MAX}) ? SSID_CLAMP : ssid_next[4:0];
            if (ssid_dig_q < SSID_DIG_SAT) ssid_dig_d = ssid_dig_q + 2'd1;
          end else begin
            failed_d = 1'b1;
          end
        end
        default: failed_d = 1'b1;
      endcase
    end

    // Verdict is judged on the state including the current character.
    sec_ok_next = (sec_d >= SEC_MIN) && (sec_d <= SEC_MAX);
    base_ok = (base_d >= BASE_MIN) && (base_d <= BASE_MAX) &&
              ((dig1_d && base_d <= 4'd7) || (dig2_d && base_d >= 4'd4));
    verdict_o = !failed_d && (total_d >= TOTAL_MIN) && (total_d <= TOTAL_MAX) && base_ok &&
                !(phase_d == PH_SEC && !sec_ok_next) &&
                !(phase_d == PH_SSID &&
                  (ssid_dig_d < 2'd1 || ssid_dig_d > 2'd2 || ssid_val_d > SSID_MAX));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_BASE;
      total_q    <= '0;
      base_q     <= '0;
      dig1_q     <= 1'b0;
      dig2_q     <= 1'b0;
      sec_q      <= '0;
      ssid_val_q <= '0;
      ssid_dig_q <= '0;
      failed_q   <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q    <= PH_BASE;
        total_q    <= '0;
        base_q     <= '0;
        dig1_q     <= 1'b0;
        dig2_q     <= 1'b0;
        sec_q      <= '0;
        ssid_val_q <= '0;
        ssid_dig_q <= '0;
        failed_q   <= 1'b0;
      end else begin
        phase_q    <= phase_d;
        total_q    <= total_d;
        base_q     <= base_d;
        dig1_q     <= dig1_d;
        dig2_q     <= dig2_d;
        sec_q      <= sec_d;
        ssid_val_q <= ssid_val_d;
        ssid_dig_q <= ssid_dig_d;
        failed_q   <= failed_d;
      end
    end
  end

endmodule

@@ rtl/callsign_ssid_validator_core.sv @@
// Callsign/SSID validator top level: input register, grammar tracker, result register.
// Throughput: one character word per cycle, unless a final word waits for the result
// register to be free; the grammar state updates in a single pass. Reset (rst_ni,
// asynchronous, active low) empties both registers and returns the tracker to the base
// phase with all counters and flags cleared. Depends on csv_pkg and the csv_in_if /
// csv_out_if interfaces.
module callsign_ssid_validator_core
  import csv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  csv_in_if.sink    in_i,
  csv_out_if.source out_o
);

  // Input register stage. It holds one character word at a time; it hands the
  // word to the tracker whenever the word is not final, or when the result
  // register is free (or being drained this cycle) for a final word.
  logic       s1_valid_q;
  logic [7:0] s1_ch_q;
  logic       s1_last_q;

  // Result register stage, which parts the output handshake from the input side.
  logic       out_valid_q;
  logic       res_q;

  logic        out_free;
  logic        s1_step;
  logic        verdict;
  char_class_t cls;

  assign out_free  = !out_valid_q || out_o.ready;
  assign s1_step   = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || s1_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_ch_q   <= in_i.ch;
      s1_last_q <= in_i.is_last;
    end
  end

  csv_classify u_classify (
    .ch_i  (s1_ch_q),
    .cls_o (cls)
  );

  // The tracker advances once per handed-over word and clears itself after a
  // final word, so the next callsign starts from the base phase.
  csv_track u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s1_step),
    .last_i    (s1_last_q),
    .cls_i     (cls),
    .verdict_o (verdict)
  );

  // Only a final character produces a result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_step && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_step && s1_last_q) begin
      res_q <= verdict;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.valid_res = res_q;

endmodule

@@ verif/csv_checker.sv @@
// Watches both channels of the callsign validator, predicts each verdict word and compares.
// Depends on csv_pkg and the csv_in_if / csv_out_if interfaces.
module csv_checker
  import csv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  csv_in_if    char_mon,
  csv_out_if   verdict_mon,
  output int   fault_count_o,
  output int   pending_o,
  output int   judged_o,
  output int   judged_valid_o
);

  // Grammar tracker state, kept at the widths of the block.
  phase_e     gr_phase;
  logic [4:0] gr_total;
  logic [3:0] gr_base;
  logic       gr_dig_one;
  logic       gr_dig_two;
  logic [2:0] gr_sec;
  logic [4:0] gr_ssid;
  logic [1:0] gr_ssid_digits;
  logic       gr_broken;

  bit verdict_q[$];
  bit wanted;

  function automatic bit digit_char(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit alnum_char(logic [7:0] c);
    return digit_char(c) || (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
  endfunction

  task automatic clear_grammar();
    gr_phase       = PH_BASE;
    gr_total       = '0;
    gr_base        = '0;
    gr_dig_one     = 1'b0;
    gr_dig_two     = 1'b0;
    gr_sec         = '0;
    gr_ssid        = '0;
    gr_ssid_digits = '0;
    gr_broken      = 1'b0;
  endtask

  task automatic absorb_char(input logic [7:0] c);
    int v;
    if (gr_total != TOTAL_SAT) gr_total++;
    if (!gr_broken) begin
      case (gr_phase)
        PH_BASE: begin
          if (alnum_char(c)) begin
            if (gr_base == 4'd1 && digit_char(c)) gr_dig_one = 1'b1;
            if (gr_base == 4'd2 && digit_char(c)) gr_dig_two = 1'b1;
            if (gr_base != BASE_SAT) gr_base++;
          end else if (c == CH_SLASH) begin
            gr_phase = PH_SEC;
          end else if (c == CH_DASH) begin
            gr_phase = PH_SSID;
          end else begin
            gr_broken = 1'b1;
          end
        end
        PH_SEC: begin
          if (alnum_char(c)) begin
            if (gr_sec != SEC_SAT) gr_sec++;
          end else if (c == CH_DASH) begin
            if (gr_sec < SEC_MIN || gr_sec > SEC_MAX) gr_broken = 1'b1;
            gr_phase = PH_SSID;
          end else begin
            gr_broken = 1'b1;
          end
        end
        default: begin
          if (digit_char(c)) begin
            v = int'(gr_ssid) * 10 + (int'(c) - int'(CH_0));
            gr_ssid = (v > int'(SSID_MAX)) ? SSID_CLAMP : 5'(v);
            if (gr_ssid_digits != SSID_DIG_SAT) gr_ssid_digits++;
          end else begin
            gr_broken = 1'b1;
          end
        end
      endcase
    end
  endtask

  function automatic bit grammar_holds();
    bit base_ok;
    // A digit at position 1 allows a base of up to seven characters, a digit at
    // position 2 needs at least four.
    base_ok = gr_base >= BASE_MIN && gr_base <= BASE_MAX &&
              ((gr_dig_one && gr_base <= BASE_MAX - 4'd1) ||
               (gr_dig_two && gr_base >= BASE_MIN + 4'd1));
    if (gr_broken || !base_ok) return 1'b0;
    if (gr_total < TOTAL_MIN || gr_total > TOTAL_MAX) return 1'b0;
    if (gr_phase == PH_SEC && (gr_sec < SEC_MIN || gr_sec > SEC_MAX)) return 1'b0;
    if (gr_phase == PH_SSID &&
        (gr_ssid_digits < 2'd1 || gr_ssid_digits > 2'd2 || gr_ssid > SSID_MAX)) return 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t checker: %s", $time, what);
    fault_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_grammar();
      verdict_q.delete();
      fault_count_o  = 0;
      pending_o      = 0;
      judged_o       = 0;
      judged_valid_o = 0;
    end else begin
      if (verdict_mon.valid && verdict_mon.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict word arrived with no callsign outstanding");
        end else begin
          wanted = verdict_q.pop_front();
          if (verdict_mon.valid_res !== wanted)
            report_mismatch($sformatf("valid_res is %b, predicted %b",
                                      verdict_mon.valid_res, wanted));
          judged_o++;
          if (wanted) judged_valid_o++;
        end
      end
      if (char_mon.valid && char_mon.ready) begin
        absorb_char(char_mon.ch);
        if (char_mon.is_last) begin
          verdict_q.push_back(grammar_holds());
          clear_grammar();
        end
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

@@ verif/tb_top.sv @@
// Top of the callsign validator testbench: clock, reset, character stimulus and verdict.
// Depends on csv_pkg, the channel interfaces, csv_checker and the validator core.
module tb_top
  import csv_pkg::*;
();

  logic clk_i;
  logic rst_ni;

  csv_in_if  in_if ();
  csv_out_if out_if ();

  int fault_count;
  int pending;
  int judged;
  int judged_valid;

  // Idle percentages of the sender and the receiver, changed per phase.
  int src_idle_pct;
  int sink_stall_pct;
  int idle_plan[4]  = '{0, 56, 0, 24};
  int stall_plan[4] = '{0, 0, 56, 24};

  int          chars_sent;
  int          calls_sent;
  logic [7:0]  call_q[$];

  callsign_ssid_validator_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  csv_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_mon      (in_if),
    .verdict_mon   (out_if),
    .fault_count_o (fault_count),
    .pending_o     (pending),
    .judged_o      (judged),
    .judged_valid_o(judged_valid)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver stalls at random; its ready is redrawn at every rising edge so
  // that stalls fall on every phase of the block's work.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Hard limit on the run, set well above what a correct run needs even with
  // both sides idling.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [7:0] alnum_byte();
    int r;
    r = $urandom_range(61);
    if (r < 10) return CH_0 + 8'(r);
    if (r < 36) return CH_UA + 8'(r - 10);
    return CH_LA + 8'(r - 36);
  endfunction

  function automatic logic [7:0] digit_byte(int top);
    return CH_0 + 8'($urandom_range(top));
  endfunction

  // Sends one character word. Before it the sender may idle; valid then stays high
  // until the word is taken, and the task returns at the edge that accepts it.
  task automatic put_word(input logic [7:0] c, input logic last);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.ch      <= c;
    in_if.is_last <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Sends the callsign held in call_q, marking its final character.
  task automatic send_call();
    for (int i = 0; i < call_q.size(); i++) begin
      put_word(call_q[i], i == call_q.size() - 1);
      chars_sent++;
    end
    calls_sent++;
  endtask

  task automatic send_text(input string s);
    call_q.delete();
    for (int i = 0; i < s.len(); i++) call_q.push_back(s[i]);
    send_call();
  endtask

  // Builds a callsign of the form BASE [/secondary] [-SSID] with random content.
  // Lengths mostly sit near the legal limits; now and then they run long enough to
  // saturate the counters, and one character in eight callsigns is overwritten by
  // an arbitrary byte.
  task automatic build_shaped_call();
    int stem_len;
    int part_len;
    call_q.delete();
    stem_len = ($urandom_range(9) == 0) ? $urandom_range(17) : $urandom_range(8, 2);
    for (int i = 0; i < stem_len; i++) call_q.push_back(alnum_byte());
    // Steer toward the two digit-position rules of the base.
    case ($urandom_range(3))
      0: if (stem_len > 1) call_q[1] = digit_byte(9);
      1: if (stem_len > 2) call_q[2] = digit_byte(9);
      default: ;
    endcase
    if ($urandom_range(2) == 0) begin
      call_q.push_back(CH_SLASH);
      part_len = ($urandom_range(5) == 0) ? $urandom_range(8) : $urandom_range(3, 1);
      for (int i = 0; i < part_len; i++) call_q.push_back(alnum_byte());
    end
    if ($urandom_range(1) == 0) begin
      call_q.push_back(CH_DASH);
      part_len = ($urandom_range(5) == 0) ? $urandom_range(4) : $urandom_range(2, 1);
      // A leading 0 or 1 keeps two-digit SSIDs in range about half the time.
      for (int i = 0; i < part_len; i++)
        call_q.push_back(digit_byte((i == 0 && part_len > 1 && $urandom_range(1) == 0) ? 1 : 9));
    end
    if (call_q.size() == 0) call_q.push_back(alnum_byte());
    if ($urandom_range(7) == 0)
      call_q[$urandom_range(call_q.size() - 1)] = 8'($urandom_range(255, 1));
  endtask

  // Builds an unstructured string: any byte, separators and digits mixed, with an
  // occasional long one that may saturate the total count.
  task automatic build_noise_call();
    int len;
    call_q.delete();
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(12, 1);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(3))
        0: call_q.push_back(8'($urandom_range(255, 1)));
        1: call_q.push_back(alnum_byte());
        2: call_q.push_back($urandom_range(1) ? CH_SLASH : CH_DASH);
        default: call_q.push_back(digit_byte(9));
      endcase
    end
  endtask

  initial begin
    int target;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    chars_sent     = 0;
    calls_sent     = 0;
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.ch      <= '0;
    in_if.is_last <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: the lowest nonzero and highest byte as one-character strings, the
    // shortest valid callsign, a full BASE/secondary-SSID form with the largest
    // SSID, a dash with no digits after it, and a slash inside the SSID part.
    call_q = '{8'h01};
    send_call();
    call_q = '{8'hFF};
    send_call();
    send_text("K1A");
    send_text("AB1C/P-15");
    send_text("K1A-");
    send_text("K1A-/");

    // Random part in four idling phases: none, sender idle, receiver stalling,
    // and both at once. Mostly shaped callsigns, the rest noise.
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = idle_plan[ph];
      sink_stall_pct = stall_plan[ph];
      target = chars_sent + 325;
      while (chars_sent < target) begin
        if ($urandom_range(99) < 70) build_shaped_call();
        else build_noise_call();
        send_call();
      end
    end
    in_if.valid <= 1'b0;

    // Drain: wait for every verdict word, then keep watching so that a stray
    // extra word would still be caught.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("summary: %0d character words in %0d callsigns, %0d verdicts checked (%0d valid)",
             chars_sent, calls_sent, judged, judged_valid);
    $display("summary: idling phases none, sender, receiver and both; %0d mismatches",
             fault_count);
    if (fault_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/csv_pkg.sv
rtl/csv_in_if.sv
rtl/csv_out_if.sv
rtl/csv_classify.sv
rtl/csv_track.sv
rtl/callsign_ssid_validator_core.sv
verif/csv_checker.sv
verif/tb_top.sv
